>>> hw/rtl/led_pattern_tick_scheduler_defines.svh
// Assertion macros for the LED pattern tick scheduler.
`ifndef LED_PATTERN_TICK_SCHEDULER_DEFINES_SVH
`define LED_PATTERN_TICK_SCHEDULER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpts assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpts assertion failed");

`endif

>>> hw/rtl/lpts_pkg.sv
// Types, constants and register indexes for the LED pattern tick scheduler.
package lpts_pkg;

    localparam int TICKS_PER_SECOND_DEF = 1000;

    localparam int DUTY_W   = 10;
    localparam int LEDCD_W  = 10;
    localparam int PHASE_W  = 4;
    localparam int TASK_W   = 16;
    localparam int UPTIME_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0]  DUTY_MAX        = 10'd1000;
    localparam logic [DUTY_W-1:0]  INTENSITY_RESET = 10'd200;
    localparam logic [LEDCD_W-1:0] HB_ON_MS        = 10'd25;
    localparam logic [LEDCD_W-1:0] HB_OFF_MS       = 10'd475;
    localparam logic [LEDCD_W-1:0] HB_OFF_STIM_MS  = 10'd975;
    localparam logic [LEDCD_W-1:0] BLINK_ON_MS     = 10'd50;
    localparam logic [LEDCD_W-1:0] BLINK_OFF_MS    = 10'd150;

    localparam logic [TASK_W-1:0] READ_PERIOD_RESET    = 16'd30000;
    localparam logic [TASK_W-1:0] UPDATE_PERIOD_RESET  = 16'd3333;
    localparam logic [TASK_W-1:0] BATTERY_PERIOD_RESET = 16'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_INTENSITY  = 3'd0,
        CFG_STIM_ON        = 3'd1,
        CFG_READ_PERIOD    = 3'd2,
        CFG_UPDATE_PERIOD  = 3'd3,
        CFG_BATTERY_PERIOD = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic tick;
        logic blink_request;
        logic ack_read;
        logic ack_update;
        logic ack_battery;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0]   led_duty;
        logic                led_lit;
        logic                blink_running;
        logic [UPTIME_W-1:0] uptime_seconds;
        logic                read_due;
        logic                update_due;
        logic                battery_due;
    } t_out_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              lit;
        logic              blink;
    } t_led_status;

endpackage

>>> hw/rtl/lpts_led_seq.sv
// LED phase sequencer: heartbeat and blink pattern with latched duty.
module lpts_led_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_tick,
    input  logic                                i_blink_request,
    input  logic [lpts_pkg::DUTY_W-1:0]         i_intensity,
    input  logic                                i_stim_on,
    output lpts_pkg::t_led_status               o_next
);
    import lpts_pkg::*;

    logic [LEDCD_W-1:0] r_cd, n_cd;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_blink, n_blink;
    logic [DUTY_W-1:0]  r_duty, n_duty;

    logic               w_blink_act;
    logic [LEDCD_W-1:0] w_cd_dec;
    logic [PHASE_W-1:0] w_ph_inc;
    logic [DUTY_W-1:0]  w_sat;

    always_comb begin
        w_blink_act = r_blink | i_blink_request;
        w_cd_dec    = r_cd - LEDCD_W'(1);
        w_ph_inc    = r_phase + PHASE_W'(1);
        w_sat       = (i_intensity > DUTY_MAX) ? DUTY_MAX : i_intensity;
        n_cd        = r_cd;
        n_phase     = r_phase;
        n_blink     = w_blink_act;
        n_duty      = r_duty;
        if (i_tick) begin
            n_cd = w_cd_dec;
            if (w_cd_dec == '0) begin
                n_duty = w_ph_inc[0] ? '0 : w_sat;
                if (w_blink_act && (w_ph_inc != '0)) begin
                    n_phase = w_ph_inc;
                    n_cd    = w_ph_inc[0] ? BLINK_OFF_MS : BLINK_ON_MS;
                end else begin
                    n_blink = 1'b0;
                    n_phase = {{(PHASE_W-1){1'b0}}, w_ph_inc[0]};
                    if (w_ph_inc[0]) begin
                        n_cd = i_stim_on ? HB_OFF_STIM_MS : HB_OFF_MS;
                    end else begin
                        n_cd = HB_ON_MS;
                    end
                end
            end
        end
        o_next.duty  = n_duty;
        o_next.lit   = ~n_phase[0];
        o_next.blink = n_blink;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd    <= HB_ON_MS;
            r_phase <= '0;
            r_blink <= 1'b0;
            r_duty  <= INTENSITY_RESET;
        end else if (i_step) begin
            r_cd    <= n_cd;
            r_phase <= n_phase;
            r_blink <= n_blink;
            r_duty  <= n_duty;
        end
    end

endmodule

>>> hw/rtl/led_pattern_tick_scheduler.sv
// Top level of the LED pattern tick scheduler.
// The input channel takes one transaction per millisecond event: a tick bit,
// a blink request and three task acknowledgements. Each input transaction
// yields exactly one output transaction with the LED duty, the LED phase,
// the blink status, the uptime in seconds and three task due flags.
// The configuration channel writes one of five registers by index; writes
// to indexes above four are ignored, and it is always ready.
// An accepted transaction is processed combinationally; its result is
// registered and presented on the output channel in the cycle after it is
// accepted; one transaction per cycle is taken unless the receiver stalls.
// The output register is the only buffer: when the receiver stalls, the
// result holds and the input channel waits until the result is taken,
// and a new transaction may be accepted in the cycle the old result leaves.
// Reset clears all counters, the LED sequencer and the configuration to
// their default values and empties the output register.
module led_pattern_tick_scheduler #(
    parameter int TICKS_PER_SECOND = lpts_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lpts_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lpts_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lpts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lpts_pkg::*;

    `include "led_pattern_tick_scheduler_defines.svh"

    localparam int PRE_W = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [PRE_W-1:0] PRE_RELOAD = PRE_W'(TICKS_PER_SECOND);

    logic [DUTY_W-1:0]   r_intensity;
    logic                r_stim_on;
    logic [TASK_W-1:0]   r_read_period, r_update_period, r_battery_period;

    logic [PRE_W-1:0]    r_pre, n_pre;
    logic [UPTIME_W-1:0] r_uptime, n_uptime;
    logic [TASK_W-1:0]   r_read_cd, n_read_cd;
    logic [TASK_W-1:0]   r_update_cd, n_update_cd;
    logic [TASK_W-1:0]   r_battery_cd, n_battery_cd;

    logic                r_out_valid;
    t_out_item           r_out, n_out;

    logic                w_accept;
    logic [PRE_W-1:0]    w_pre_dec;
    t_led_status         w_led;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign w_accept    = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity      <= INTENSITY_RESET;
            r_stim_on        <= 1'b0;
            r_read_period    <= READ_PERIOD_RESET;
            r_update_period  <= UPDATE_PERIOD_RESET;
            r_battery_period <= BATTERY_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LED_INTENSITY:  r_intensity      <= i_cfg_data[DUTY_W-1:0];
                CFG_STIM_ON:        r_stim_on        <= i_cfg_data[0];
                CFG_READ_PERIOD:    r_read_period    <= i_cfg_data[TASK_W-1:0];
                CFG_UPDATE_PERIOD:  r_update_period  <= i_cfg_data[TASK_W-1:0];
                CFG_BATTERY_PERIOD: r_battery_period <= i_cfg_data[TASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lpts_led_seq u_led_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_accept),
        .i_tick          (i_in.tick),
        .i_blink_request (i_in.blink_request),
        .i_intensity     (r_intensity),
        .i_stim_on       (r_stim_on),
        .o_next          (w_led)
    );

    always_comb begin
        w_pre_dec    = r_pre - PRE_W'(1);
        n_pre        = r_pre;
        n_uptime     = r_uptime;
        n_read_cd    = i_in.ack_read    ? (r_read_period - TASK_W'(1))    : r_read_cd;
        n_update_cd  = i_in.ack_update  ? (r_update_period - TASK_W'(1))  : r_update_cd;
        n_battery_cd = i_in.ack_battery ? (r_battery_period - TASK_W'(1)) : r_battery_cd;
        if (i_in.tick) begin
            if (w_pre_dec == '0) begin
                n_pre    = PRE_RELOAD;
                n_uptime = r_uptime + UPTIME_W'(1);
            end else begin
                n_pre = w_pre_dec;
            end
            n_read_cd    = n_read_cd - TASK_W'(1);
            n_update_cd  = n_update_cd - TASK_W'(1);
            n_battery_cd = n_battery_cd - TASK_W'(1);
        end
        n_out.led_duty       = w_led.duty;
        n_out.led_lit        = w_led.lit;
        n_out.blink_running  = w_led.blink;
        n_out.uptime_seconds = n_uptime;
        n_out.read_due       = (n_read_cd == '0);
        n_out.update_due     = (n_update_cd == '0);
        n_out.battery_due    = (n_battery_cd == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre        <= PRE_RELOAD;
            r_uptime     <= '0;
            r_read_cd    <= READ_PERIOD_RESET - TASK_W'(1);
            r_update_cd  <= UPDATE_PERIOD_RESET - TASK_W'(1);
            r_battery_cd <= BATTERY_PERIOD_RESET - TASK_W'(1);
        end else if (w_accept) begin
            r_pre        <= n_pre;
            r_uptime     <= n_uptime;
            r_read_cd    <= n_read_cd;
            r_update_cd  <= n_update_cd;
            r_battery_cd <= n_battery_cd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    `LPTS_ASSERT_SAME(a_dark_duty_zero, i_clk, i_rst_n, r_out_valid && !r_out.led_lit, r_out.led_duty == '0)
    `LPTS_ASSERT_SAME(a_duty_limit, i_clk, i_rst_n, r_out_valid, r_out.led_duty <= DUTY_MAX)
    `LPTS_ASSERT_NEXT(a_uptime_step, i_clk, i_rst_n, w_accept, (r_uptime == $past(r_uptime)) || (r_uptime == $past(r_uptime) + UPTIME_W'(1)))

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking LED pattern tick scheduler bench: directed and random traffic vs. a predictor.
module tb;
    import lpts_pkg::*;

    localparam int RANDOM_PER_SETTING = 475;
    localparam int HOLD_AT            = 1100;
    localparam int HOLD_CYCLES        = 120;
    localparam int REPORT_LIMIT       = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Field order: {tick, blink_request, ack_read, ack_update, ack_battery}.
    logic [4:0] directed_cmds [12] = '{
        5'b00000, 5'b10000, 5'b00100, 5'b00010, 5'b00001, 5'b10111,
        5'b00111, 5'b10000, 5'b01000, 5'b11000, 5'b11111, 5'b10000
    };

    t_in_item  cmd_queue[$];
    t_out_item expected_status[$];
    t_out_item want;
    int        n_accepted = 0;
    int        n_mismatch = 0;
    int        send_idle_pct = 14;
    int        recv_idle_pct = 72;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    logic [DUTY_W-1:0]   cfg_intensity = INTENSITY_RESET;
    logic                cfg_stim = 1'b0;
    logic [TASK_W-1:0]   cfg_read_period = READ_PERIOD_RESET;
    logic [TASK_W-1:0]   cfg_update_period = UPDATE_PERIOD_RESET;
    logic [TASK_W-1:0]   cfg_battery_period = BATTERY_PERIOD_RESET;

    logic [LEDCD_W-1:0]  sec_presc = LEDCD_W'(TICKS_PER_SECOND_DEF);
    logic [UPTIME_W-1:0] uptime = '0;
    logic [TASK_W-1:0]   read_cnt = READ_PERIOD_RESET - 1'b1;
    logic [TASK_W-1:0]   update_cnt = UPDATE_PERIOD_RESET - 1'b1;
    logic [TASK_W-1:0]   battery_cnt = BATTERY_PERIOD_RESET - 1'b1;
    logic [LEDCD_W-1:0]  led_cnt = HB_ON_MS;
    logic [PHASE_W-1:0]  led_step = '0;
    logic                blinking = 1'b0;
    logic [DUTY_W-1:0]   duty_latched = INTENSITY_RESET;

    led_pattern_tick_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic string status_text(input t_out_item s);
        return $sformatf("duty=%0d lit=%b blink=%b uptime=%0d due(r/u/b)=%b%b%b",
                         s.led_duty, s.led_lit, s.blink_running, s.uptime_seconds,
                         s.read_due, s.update_due, s.battery_due);
    endfunction

    function automatic t_in_item random_command();
        t_in_item c;
        c.tick          = $urandom_range(15) != 0;
        c.blink_request = $urandom_range(39) == 0;
        c.ack_read      = $urandom_range(7) == 0;
        c.ack_update    = $urandom_range(7) == 0;
        c.ack_battery   = $urandom_range(7) == 0;
        return c;
    endfunction

    // Advances the predicted scheduler by one transaction and queues its status.
    task automatic apply_command(input t_in_item cmd);
        t_out_item res;
        if (cmd.blink_request) begin
            blinking = 1'b1;
        end
        if (cmd.ack_read) begin
            read_cnt = cfg_read_period - 1'b1;
        end
        if (cmd.ack_update) begin
            update_cnt = cfg_update_period - 1'b1;
        end
        if (cmd.ack_battery) begin
            battery_cnt = cfg_battery_period - 1'b1;
        end
        if (cmd.tick) begin
            sec_presc = sec_presc - 1'b1;
            if (sec_presc == '0) begin
                uptime = uptime + 1'b1;
                sec_presc = LEDCD_W'(TICKS_PER_SECOND_DEF);
            end
            read_cnt = read_cnt - 1'b1;
            update_cnt = update_cnt - 1'b1;
            battery_cnt = battery_cnt - 1'b1;
            led_cnt = led_cnt - 1'b1;
            if (led_cnt == '0) begin
                led_step = led_step + 1'b1;
                if (led_step[0]) begin
                    duty_latched = '0;
                end else begin
                    duty_latched = (cfg_intensity > DUTY_MAX) ? DUTY_MAX : cfg_intensity;
                end
                if (blinking && led_step != '0) begin
                    led_cnt = led_step[0] ? BLINK_OFF_MS : BLINK_ON_MS;
                end else begin
                    blinking = 1'b0;
                    led_step = {3'b000, led_step[0]};
                    if (!led_step[0]) begin
                        led_cnt = HB_ON_MS;
                    end else begin
                        led_cnt = cfg_stim ? HB_OFF_STIM_MS : HB_OFF_MS;
                    end
                end
            end
        end
        res.led_duty       = duty_latched;
        res.led_lit        = ~led_step[0];
        res.blink_running  = blinking;
        res.uptime_seconds = uptime;
        res.read_due       = read_cnt == '0;
        res.update_due     = update_cnt == '0;
        res.battery_due    = battery_cnt == '0;
        expected_status.push_back(res);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            n_accepted <= 0;
        end else begin
            if (in_valid && in_ready) begin
                apply_command(in_item);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || in_ready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item <= cmd_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready) begin
                if (expected_status.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_LIMIT) begin
                        $display("unexpected status transaction: %s", status_text(out_item));
                    end
                end else begin
                    want = expected_status.pop_front();
                    if (out_item.led_duty !== want.led_duty
                            || out_item.led_lit !== want.led_lit
                            || out_item.blink_running !== want.blink_running
                            || out_item.uptime_seconds !== want.uptime_seconds
                            || out_item.read_due !== want.read_due
                            || out_item.update_due !== want.update_due
                            || out_item.battery_due !== want.battery_due) begin
                        n_mismatch++;
                        if (n_mismatch <= REPORT_LIMIT) begin
                            $display("status mismatch at %0t: expected %s", $realtime,
                                     status_text(want));
                            $display("                       got      %s",
                                     status_text(out_item));
                        end
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || expected_status.size() != 0 || in_valid) begin
            @(negedge clk);
        end
    endtask

    // Programs all registers while the block is idle, then queues random commands.
    task automatic run_setting(input logic [CFG_DATA_W-1:0] intensity, stim,
                               input logic [CFG_DATA_W-1:0] rd_period, up_period, bat_period,
                               input bit poke_unused, input int send_pct, input int recv_pct);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        int n;
        int k;
        idx = '{CFG_LED_INTENSITY, CFG_STIM_ON, CFG_READ_PERIOD, CFG_UPDATE_PERIOD,
                CFG_BATTERY_PERIOD, CFG_UNUSED_INDEX};
        val = '{intensity, stim, rd_period, up_period, bat_period, 16'hFFFF};
        n = poke_unused ? 6 : 5;
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge clk);
        for (k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                CFG_LED_INTENSITY:  cfg_intensity = val[k][DUTY_W-1:0];
                CFG_STIM_ON:        cfg_stim = val[k][0];
                CFG_READ_PERIOD:    cfg_read_period = val[k];
                CFG_UPDATE_PERIOD:  cfg_update_period = val[k];
                CFG_BATTERY_PERIOD: cfg_battery_period = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
        repeat (RANDOM_PER_SETTING) cmd_queue.push_back(random_command());
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_cmds[i]) cmd_queue.push_back(t_in_item'(directed_cmds[i]));
        run_setting(16'd1000, 16'd0, 16'd1, 16'd2, 16'd3, 1'b0, 14, 72);
        run_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd5, 1'b1, 72, 14);
        run_setting(16'hFC00, 16'hFFFE, 16'd4, 16'd1, 16'd0, 1'b0, 0, 0);
        run_setting(16'($urandom_range(1023)), 16'd1, 16'($urandom_range(1, 8)),
                    16'($urandom_range(1, 8)), 16'($urandom_range(1, 65535)), 1'b0, 0, 0);
        wait_drained();
        repeat (4) @(posedge clk);
        if (n_mismatch == 0 && expected_status.size() == 0) begin
            $display("led_pattern_tick_scheduler test passed");
        end else begin
            $display("led_pattern_tick_scheduler test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("led_pattern_tick_scheduler test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lpts_pkg.sv
hw/rtl/lpts_led_seq.sv
hw/rtl/led_pattern_tick_scheduler.sv
tb/tb.sv
